@@ src/buzzer_pattern_sequencer_macros.svh @@
// Assertion macros for the buzzer pattern sequencer.
// No dependencies; included by the top level, which holds all assertions.
`ifndef BUZZER_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define BPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bps assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bps assertion failed: next-cycle implication");

`else

`define BPS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/bps_pkg.sv @@
// Types, constants and pattern tables for the buzzer pattern sequencer.
// No dependencies; used by buzzer_pattern_sequencer.
`default_nettype none

package bps_pkg;

   localparam int unsigned NUM_PATTERNS = 16;
   localparam int unsigned MAX_SWITCH   = 7;

   localparam logic       MODE_TICK    = 1'b0;
   localparam logic       MODE_REQUEST = 1'b1;

   localparam logic [3:0] PAT_IDLE     = 4'd0;
   localparam logic [3:0] PAT_INVALID  = 4'd15;

   localparam logic [7:0] COUNT_ZERO   = 8'd0;
   localparam logic [7:0] COUNT_ONE    = 8'd1;
   localparam logic [7:0] COUNT_END    = 8'd10;

   typedef struct packed {
      logic       mode;
      logic [3:0] pattern;
   } req_word_type;

   typedef struct packed {
      logic       buzzer_on;
      logic [3:0] active_pattern;
      logic [7:0] countdown;
   } rsp_word_type;

   typedef struct packed {
      logic hit;
      logic level;
   } switch_type;

   // Pattern length loaded into the countdown. The invalid code has a dummy row.
   localparam logic [7:0] PAT_LEN [0:NUM_PATTERNS-1] = '{
      8'd0,   8'd16,  8'd28,  8'd130, 8'd150, 8'd170, 8'd222, 8'd40,
      8'd22,  8'd200, 8'd200, 8'd200, 8'd250, 8'd250, 8'd250, 8'd0
   };

   localparam logic PAT_REPEAT [0:NUM_PATTERNS-1] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
   };

   localparam logic [2:0] PAT_NSW [0:NUM_PATTERNS-1] = '{
      3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd6, 3'd2, 3'd4,
      3'd1, 3'd1, 3'd3, 3'd5, 3'd3, 3'd5, 3'd7, 3'd0
   };

   // Switch points, first match wins.
   localparam logic [7:0] PAT_AT [0:NUM_PATTERNS-1][0:MAX_SWITCH-1] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd22,  8'd16,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd30,  8'd20,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd50,  8'd40,  8'd30,  8'd20,  8'd0,   8'd0,   8'd0},
      '{8'd70,  8'd60,  8'd50,  8'd40,  8'd30,  8'd20,  8'd0},
      '{8'd122, 8'd110, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd34,  8'd28,  8'd22,  8'd16,  8'd0,   8'd0,   8'd0},
      '{8'd16,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd195, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd196, 8'd192, 8'd188, 8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd196, 8'd192, 8'd188, 8'd184, 8'd180, 8'd0,   8'd0},
      '{8'd180, 8'd160, 8'd155, 8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd180, 8'd160, 8'd155, 8'd150, 8'd145, 8'd0,   8'd0},
      '{8'd180, 8'd160, 8'd155, 8'd150, 8'd145, 8'd140, 8'd135},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
   };

   // Level at each switch point, bit i for point i.
   localparam logic [MAX_SWITCH-1:0] PAT_LV [0:NUM_PATTERNS-1] = '{
      7'b0000000, 7'b0000000, 7'b0000010, 7'b0000010,
      7'b0001010, 7'b0101010, 7'b0000010, 7'b0001010,
      7'b0000000, 7'b0000000, 7'b0000010, 7'b0001010,
      7'b0000010, 7'b0001010, 7'b0101010, 7'b0000000
   };

   // Look up the switch point of a pattern at a countdown value.
   function automatic switch_type pat_switch(input logic [3:0] pat, input logic [7:0] cnt);
      switch_type sw;
      sw.hit   = 1'b0;
      sw.level = 1'b0;
      for (int i = 0; i < MAX_SWITCH; i++) begin
         if (!sw.hit && (3'(i) < PAT_NSW[pat]) && (PAT_AT[pat][i] == cnt)) begin
            sw.hit   = 1'b1;
            sw.level = PAT_LV[pat][i];
         end
      end
      return sw;
   endfunction

endpackage

`default_nettype wire

@@ src/buzzer_pattern_sequencer.sv @@
// Buzzer pattern sequencer top level: input register, pattern step, result register.
// Depends on bps_pkg and buzzer_pattern_sequencer_macros.svh.
//
// Usage:
//   The req channel carries one word per tick or pattern request
//   (mode 0 = timer tick, mode 1 = request of the pattern in the word).
//   The rsp channel returns one word per request word: buzzer level,
//   active pattern and countdown after that step.
//   Both channels use valid/stall; a word moves when valid is high and
//   stall is low at a rising clock edge.
// Path: an accepted word goes into the input register, then through the
//   pattern step into the result register, where rsp_valid is high.
// Throughput: one word per cycle while rsp_stall is low; the pattern step is a
//   table lookup and a handful of 8-bit compares, done combinationally between
//   the input and result registers; the state registers update as the word advances.
// Stall: while rsp_stall holds the result register, the input register still
//   takes one more word; req_stall rises only when both are full.
// Reset: synchronous, active high; both stages empty, pattern idle,
//   countdown 0, buzzer off.
`default_nettype none
`include "buzzer_pattern_sequencer_macros.svh"

module buzzer_pattern_sequencer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire bps_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output bps_pkg::rsp_word_type rsp_word
);

   // Input stage
   logic                  in_valid_ff, in_valid_in;
   bps_pkg::req_word_type in_word_ff,  in_word_in;

   // Sequencer state
   logic [3:0] pattern_ff, pattern_in;
   logic [7:0] count_ff,   count_in;
   logic       level_ff,   level_in;

   // Result stage
   logic                  out_valid_ff, out_valid_in;
   bps_pkg::rsp_word_type out_word_ff,  out_word_in;

   logic                  advance;
   logic                  rsp_take;
   logic                  req_take;
   bps_pkg::switch_type   sw;

   assign rsp_take  = out_valid_ff && !rsp_stall;
   // Move the input word into the result stage when that stage is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_take);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // Pattern step
   always_comb begin
      pattern_in = pattern_ff;
      count_in   = count_ff;
      level_in   = level_ff;
      sw         = '{hit: 1'b0, level: 1'b0};

      if (in_word_ff.mode == bps_pkg::MODE_TICK) begin
         // Count down only above the end mark.
         if (count_ff > bps_pkg::COUNT_END) begin
            count_in = count_ff - 8'd1;
         end
      end else begin
         // A new pattern restarts from a cleared countdown.
         if (pattern_ff != in_word_ff.pattern) begin
            pattern_in = in_word_ff.pattern;
            count_in   = bps_pkg::COUNT_ZERO;
         end
         sw = bps_pkg::pat_switch(pattern_in, count_in);

         if (pattern_in == bps_pkg::PAT_IDLE) begin
            count_in = bps_pkg::COUNT_ZERO;
            level_in = 1'b0;
         end else if (pattern_in == bps_pkg::PAT_INVALID) begin
            // Drop to idle, leave the buzzer level as it is.
            pattern_in = bps_pkg::PAT_IDLE;
            count_in   = bps_pkg::COUNT_ZERO;
         end else if (count_in == bps_pkg::COUNT_ZERO ||
                      (bps_pkg::PAT_REPEAT[pattern_in] &&
                       (count_in == bps_pkg::COUNT_END || count_in == bps_pkg::COUNT_ONE))) begin
            count_in = bps_pkg::PAT_LEN[pattern_in];
            level_in = 1'b1;
         end else if (count_in == bps_pkg::COUNT_END) begin
            // One-shot pattern finished.
            count_in   = bps_pkg::COUNT_ZERO;
            pattern_in = bps_pkg::PAT_IDLE;
            level_in   = 1'b0;
         end else if (sw.hit) begin
            level_in = sw.level;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in               = 1'b1;
         out_word_in.buzzer_on      = level_in;
         out_word_in.active_pattern = pattern_in;
         out_word_in.countdown      = count_in;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pattern_ff   <= bps_pkg::PAT_IDLE;
         count_ff     <= bps_pkg::COUNT_ZERO;
         level_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pattern_ff <= pattern_in;
            count_ff   <= count_in;
            level_ff   <= level_in;
         end
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   // Idle pattern always sits at countdown zero.
   `BPS_ASSERT_IMPLY(a_idle_count, clock, reset,
      pattern_ff == bps_pkg::PAT_IDLE, count_ff == bps_pkg::COUNT_ZERO)
   // Stall only while a word waits in the input stage.
   `BPS_ASSERT_IMPLY(a_stall_held, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   // An advanced word lands in the result stage.
   `BPS_ASSERT_NEXT(a_advance_out, clock, reset,
      advance, out_valid_ff && out_word_ff.countdown == count_ff)

endmodule

`default_nettype wire
